// ----- rtl/core/windowed_periodic_alarm_unit_defines.svh -----
// assertion macros shared by the alarm unit rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef WINDOWED_PERIODIC_ALARM_UNIT_DEFINES_SVH
`define WINDOWED_PERIODIC_ALARM_UNIT_DEFINES_SVH

// same-cycle implication
`define WPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpa assertion failed");

// next-cycle implication
`define WPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpa assertion failed");

`endif

// ----- rtl/core/wpa_pkg.sv -----
// shared types and constants of the windowed periodic alarm unit
// no dependencies
package wpa_pkg;

  localparam int unsigned IO_W          = 32;
  localparam int unsigned OFS_W         = 17;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [OFS_W:0]   DAY_SECONDS = 18'd86400;
  localparam logic [OFS_W-1:0] DIST_MAX    = '1;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_PERIOD = 3'd1,
    REG_END    = 3'd2,
    REG_ENDV   = 3'd3,
    REG_RUN    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [OFS_W-1:0] start_offset;
    logic [OFS_W-1:0] period_seconds;
    logic [OFS_W-1:0] end_offset;
    logic             end_valid;
    logic             run_enable;
  } cfg_t;

endpackage

// ----- rtl/core/wpa_cfg_regs.sv -----
// configuration register file of the alarm unit
// depends on wpa_pkg
module wpa_cfg_regs import wpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [OFS_W-1:0] cfg_data,
  output cfg_t             cfg,
  output logic             disarm
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    disarm  = 1'b0;
    if (wr) begin
      unique case (cfg_index)
        REG_START:  cfg_nxt.start_offset   = cfg_data;
        REG_PERIOD: cfg_nxt.period_seconds = cfg_data;
        REG_END:    cfg_nxt.end_offset     = cfg_data;
        REG_ENDV:   cfg_nxt.end_valid      = cfg_data[0];
        REG_RUN: begin
          cfg_nxt.run_enable = cfg_data[0];
          disarm             = ~cfg_data[0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/wpa_rem_div.sv -----
// bit-serial restoring remainder unit: one dividend bit per cycle
// depends on wpa_pkg and the shared assertion macros
`include "windowed_periodic_alarm_unit_defines.svh"
module wpa_rem_div import wpa_pkg::*; #(
  parameter int unsigned DW = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [OFS_W-1:0] divisor,
  output logic             done,
  output logic [OFS_W-1:0] rem
);

  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0]    shift_r;
  logic [OFS_W-1:0] rem_r, rem_nxt;
  logic [OFS_W-1:0] div_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [OFS_W:0]   trial;
  logic [OFS_W:0]   diff;

  assign trial = {rem_r, shift_r[DW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[OFS_W-1:0];
    end else begin
      rem_nxt = trial[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
      div_r   <= divisor;
      cnt_r   <= CW'(DW - 1);
    end else if (run_r) begin
      shift_r <= {shift_r[DW-2:0], 1'b0};
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `WPA_ASSERT_IMPL(a_rem_below_div, done_r, rem_r < div_r)

endmodule

// ----- rtl/core/windowed_periodic_alarm_unit.sv -----
// Windowed periodic alarm. Each input beat is one time tick (current second and
// today's midnight); each tick yields exactly one result beat with fire, armed,
// in_window, seconds_to_next and bad_period.
// Channels: in_/out_ use valid and stall, a beat moves when valid is high and
// stall low. cfg_ writes register cfg_index with cfg_data when cfg_valid and
// cfg_ready are high; cfg_ready is always high, writes belong to idle periods.
// A tick that does not arm goes from the check state to the final state; one
// that arms with the start still ahead of now passes the check, base, difference,
// window and final states; one that arms past the start also runs the
// bit-serial remainder unit, one dividend bit per cycle, and the advance state
// before the window state. One tick is in work at a time; the next one is taken
// the cycle after the result lands in the output register, even while the
// receiver stalls. A stalled result holds in the output register; the
// sequencer waits in its final state until that register frees.
// Reset idles the sequencer, clears config, disarms the alarm, empties output.
// Depends on wpa_pkg, wpa_cfg_regs, wpa_rem_div and the assertion macros.
`include "windowed_periodic_alarm_unit_defines.svh"
module windowed_periodic_alarm_unit import wpa_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [OFS_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IO_W-1:0]  in_now_seconds,
  input  logic [IO_W-1:0]  in_midnight_seconds,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_fire,
  output logic             out_armed,
  output logic             out_in_window,
  output logic [OFS_W-1:0] out_seconds_to_next,
  output logic             out_bad_period
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned NW = TIME_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_BASE  = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_ADV   = 8'b0010_0000,
    S_WIN   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  cfg_t cfg;
  logic disarm;

  state_t         state_r, state_nxt;
  logic [TW-1:0]  now_in, mid_in;
  logic [TW-1:0]  now_r, mid_r;
  logic [NW-1:0]  next_ev_r, next_ev_nxt;
  logic           armed_r, armed_nxt;
  logic           wok_r, wok_nxt;
  logic           fire_r, fire_nxt;
  logic           bad_r, bad_nxt;
  logic [NW-1:0]  base_r, base_nxt;
  logic [NW-1:0]  cand_r, cand_nxt;

  logic           in_acc;
  logic           out_load;
  logic           hit;
  logic [NW-1:0]  now_x;
  logic [NW-1:0]  span;
  logic [NW-1:0]  gap;
  logic [NW-1:0]  lim;
  logic [OFS_W:0] endv;
  logic [OFS_W-1:0] to_next;
  logic           div_start;
  logic           div_done;
  logic [OFS_W-1:0] div_rem;

  logic             out_valid_r;
  logic             out_fire_r, out_armed_r, out_in_window_r, out_bad_r;
  logic [OFS_W-1:0] out_dist_r;

  wpa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .disarm    (disarm)
  );

  // fold the input fields to the configured time width
  if (TW > IO_W) begin : g_wide
    assign now_in = {{(TW - IO_W){1'b0}}, in_now_seconds};
    assign mid_in = {{(TW - IO_W){1'b0}}, in_midnight_seconds};
  end else begin : g_narrow
    assign now_in = in_now_seconds[TW-1:0];
    assign mid_in = in_midnight_seconds[TW-1:0];
  end

  assign now_x    = {1'b0, now_r};
  assign span     = now_x - base_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign hit      = armed_r && (now_x >= next_ev_r);

  // window end wraps by one day when it lies before the start
  assign endv = (cfg.end_offset < cfg.start_offset) ?
                ({1'b0, cfg.end_offset} + DAY_SECONDS) : {1'b0, cfg.end_offset};
  assign lim  = {1'b0, mid_r} + NW'(endv);

  assign gap = next_ev_r - now_x;
  always_comb begin
    to_next = '0;
    if (armed_r && next_ev_r > now_x) begin
      if (gap > NW'(DIST_MAX)) begin
        to_next = DIST_MAX;
      end else begin
        to_next = gap[OFS_W-1:0];
      end
    end
  end

  wpa_rem_div #(.DW(TW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span[TW-1:0]),
    .divisor  (cfg.period_seconds),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt   = state_r;
    next_ev_nxt = next_ev_r;
    armed_nxt   = armed_r;
    wok_nxt     = wok_r;
    fire_nxt    = fire_r;
    bad_nxt     = bad_r;
    base_nxt    = base_r;
    cand_nxt    = cand_r;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        fire_nxt  = 1'b0;
        bad_nxt   = 1'b0;
        state_nxt = S_FIN;
        if (cfg.run_enable) begin
          fire_nxt = hit & wok_r;
          if (hit) armed_nxt = 1'b0;
          if (!armed_r || hit) begin
            if (cfg.period_seconds == '0) begin
              bad_nxt = 1'b1;
            end else begin
              state_nxt = S_BASE;
            end
          end
        end
      end
      S_BASE: begin
        base_nxt  = {1'b0, mid_r} + NW'(cfg.start_offset);
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (base_r <= now_x) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cand_nxt  = base_r;
          state_nxt = S_WIN;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ADV;
      end
      S_ADV: begin
        // next event = now + period - ((now - base) mod period)
        cand_nxt  = now_x + NW'(cfg.period_seconds - div_rem);
        state_nxt = S_WIN;
      end
      S_WIN: begin
        wok_nxt     = ~cfg.end_valid | (cand_r <= lim);
        next_ev_nxt = cand_r;
        armed_nxt   = cfg.run_enable;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      wok_r       <= 1'b0;
      next_ev_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      armed_r   <= disarm ? 1'b0 : armed_nxt;
      wok_r     <= wok_nxt;
      next_ev_r <= next_ev_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= now_in;
      mid_r <= mid_in;
    end
    fire_r <= fire_nxt;
    bad_r  <= bad_nxt;
    base_r <= base_nxt;
    cand_r <= cand_nxt;
    if (out_load) begin
      out_fire_r      <= fire_r;
      out_armed_r     <= armed_r;
      out_in_window_r <= armed_r & wok_r;
      out_dist_r      <= to_next;
      out_bad_r       <= bad_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_fire            = out_fire_r;
  assign out_armed           = out_armed_r;
  assign out_in_window       = out_in_window_r;
  assign out_seconds_to_next = out_dist_r;
  assign out_bad_period      = out_bad_r;

  `WPA_ASSERT_IMPL(a_armed_needs_run, armed_r, cfg.run_enable)
  `WPA_ASSERT_IMPL(a_event_after_now, state_r == S_WIN, cand_r > now_x)
  `WPA_ASSERT_IMPL(a_idle_result_quiet, out_valid_r && !out_armed_r, (out_dist_r == '0) && !out_in_window_r)

endmodule
